// ===== rtl/core/twcb_pkg.sv =====
// Shared widths, codes, beat types and helpers of the timed write-combining buffer.
package twcb_pkg;

    localparam int ADDR_W     = 48;
    localparam int LINE_SHIFT = 6;
    localparam int LINE_W     = ADDR_W - LINE_SHIFT;
    localparam int NOW_W      = 48;
    localparam int TIME_W     = 52;
    localparam int SUM_W      = TIME_W + 1;
    localparam int WT_W       = 20;
    localparam int RING_W     = 7;
    localparam int OCC_W      = 6;
    localparam int TOTAL_W    = 32;
    localparam int CFG_DATA_W = 20;
    localparam int DEPTH_DEF  = 64;
    localparam int TREE_SHIFT = 3;

    localparam logic [RING_W-1:0] RING_RESET = RING_W'(9);

    // Request kinds
    localparam logic REQ_FENCE = 1'b1;

    // Configuration register indexes
    localparam logic [0:0] CFG_WRITE_TIME = 1'b0;
    localparam logic [0:0] CFG_RING_SIZE  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] byte_address;
        logic [NOW_W-1:0]  now_ns;
    } t_req;

    typedef struct packed {
        logic               combined;
        logic [TIME_W-1:0]  wait_ns;
        logic [TIME_W-1:0]  ready_time;
        logic [OCC_W-1:0]   occupancy;
        logic [TOTAL_W-1:0] combine_total;
    } t_res;

    typedef struct packed {
        logic [0:0]            index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic              pop;
        logic              append;
        logic [LINE_W-1:0] line;
        logic [TIME_W-1:0] start;
    } t_cell_ctl;

    // Registered levels of the radix-8 match tree over n leaves
    function automatic int tree_levels(input int n);
        int lv;
        int span;
        lv   = 1;
        span = 1 << TREE_SHIFT;
        while (span < n) begin
            span = span << TREE_SHIFT;
            lv   = lv + 1;
        end
        return lv;
    endfunction

endpackage

// ===== rtl/core/twcb_stream_if.sv =====
// Valid/ready channel carrying one beat of a typed payload.
interface twcb_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/twcb_cell.sv =====
// One ring entry: line and write start, shifting toward the head on a pop.
module twcb_cell (
    input  logic                           i_clk,
    input  twcb_pkg::t_cell_ctl            i_ctl,
    input  logic                           i_live,
    input  logic                           i_load,
    input  logic [twcb_pkg::LINE_W-1:0]    i_next_line,
    input  logic [twcb_pkg::TIME_W-1:0]    i_next_start,
    output logic [twcb_pkg::LINE_W-1:0]    o_line,
    output logic [twcb_pkg::TIME_W-1:0]    o_start,
    output logic                           o_hit
);

    logic [twcb_pkg::LINE_W-1:0] r_line;
    logic [twcb_pkg::LINE_W-1:0] n_line;
    logic [twcb_pkg::TIME_W-1:0] r_start;
    logic [twcb_pkg::TIME_W-1:0] n_start;

    // Take the neighbor's entry on a pop, the new entry when this is the tail slot
    always_comb begin
        n_line  = r_line;
        n_start = r_start;
        if (i_ctl.pop) begin
            n_line  = i_next_line;
            n_start = i_next_start;
        end else if (i_ctl.append && i_load) begin
            n_line  = i_ctl.line;
            n_start = i_ctl.start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_line  <= n_line;
        r_start <= n_start;
    end

    // Flag a live entry of the requested line
    assign o_hit   = i_live && (r_line == i_ctl.line);
    assign o_line  = r_line;
    assign o_start = r_start;

endmodule

// ===== rtl/core/twcb_hit_tree.sv =====
// Registered radix-8 reduction of the cell hit flags and the start of the hit entry.
module twcb_hit_tree #(
    parameter int N = twcb_pkg::DEPTH_DEF - 1
) (
    input  logic                        i_clk,
    input  logic [N-1:0]                i_hit,
    input  logic [twcb_pkg::TIME_W-1:0] i_start [N],
    output logic                        o_hit,
    output logic [twcb_pkg::TIME_W-1:0] o_start
);

    localparam int LVLS   = twcb_pkg::tree_levels(N);
    localparam int SH     = twcb_pkg::TREE_SHIFT;
    localparam int RADIX  = 1 << SH;
    localparam int LEAVES = 1 << (SH * LVLS);
    localparam int TW     = twcb_pkg::TIME_W;

    logic          w_leaf_hit   [LEAVES];
    logic [TW-1:0] w_leaf_start [LEAVES];
    logic          r_hit   [LVLS][LEAVES];
    logic          n_hit   [LVLS][LEAVES];
    logic [TW-1:0] r_start [LVLS][LEAVES];
    logic [TW-1:0] n_start [LVLS][LEAVES];

    // Pad to a full tree and mask starts of entries that do not match
    always_comb begin
        for (int i = 0; i < LEAVES; i++) begin
            w_leaf_hit[i]   = 1'b0;
            w_leaf_start[i] = '0;
            if (i < N) begin
                w_leaf_hit[i]   = i_hit[i];
                w_leaf_start[i] = i_hit[i] ? i_start[i] : '0;
            end
        end
    end

    // Merge groups of eight nodes per level; at most one leaf matches
    always_comb begin
        for (int lv = 0; lv < LVLS; lv++) begin
            for (int j = 0; j < LEAVES; j++) begin
                n_hit[lv][j]   = 1'b0;
                n_start[lv][j] = '0;
                if (j < (LEAVES >> (SH * (lv + 1)))) begin
                    for (int k = 0; k < RADIX; k++) begin
                        if (lv == 0) begin
                            n_hit[lv][j]   = n_hit[lv][j] | w_leaf_hit[RADIX * j + k];
                            n_start[lv][j] = n_start[lv][j] | w_leaf_start[RADIX * j + k];
                        end else begin
                            n_hit[lv][j]   = n_hit[lv][j] | r_hit[lv-1][RADIX * j + k];
                            n_start[lv][j] = n_start[lv][j] | r_start[lv-1][RADIX * j + k];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= n_hit;
        r_start <= n_start;
    end

    assign o_hit   = r_hit[LVLS-1][0];
    assign o_start = r_start[LVLS-1][0];

endmodule

// ===== rtl/core/timed_write_combining_buffer_top.sv =====
// Top level of the timed write-combining buffer: head control, cell row and match tree.
// A store retires expired head entries, then waits on the match tree, whose levels number
//   ceil(log8(DEPTH-1)), at least 1, and then combines or appends. A store into a full ring
//   retires the head before it appends; a fence drains every live entry; with write time 0 an
//   item passes straight through. One item is in work at a time.
// Reset (synchronous, active low) empties the ring, clears the combine count, sets write time 0
//   and ring size 9; entry storage needs no clearing pass.
module timed_write_combining_buffer_top #(
    parameter int DEPTH = twcb_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    twcb_stream_if.sink   i_req,
    twcb_stream_if.source o_res,
    twcb_stream_if.sink   i_cfg
);

    localparam int NCELL  = DEPTH - 1;
    localparam int CNTW   = $clog2(DEPTH);
    localparam int LVLS   = twcb_pkg::tree_levels(NCELL);
    localparam int MWW    = $clog2(LVLS + 1);
    localparam int RW     = (CNTW + 1 > twcb_pkg::RING_W) ? CNTW + 1 : twcb_pkg::RING_W;
    localparam int LW     = twcb_pkg::LINE_W;
    localparam int TW     = twcb_pkg::TIME_W;
    localparam int SW     = twcb_pkg::SUM_W;
    localparam int NW     = twcb_pkg::NOW_W;
    localparam int WTW    = twcb_pkg::WT_W;
    localparam int RGW    = twcb_pkg::RING_W;
    localparam int OCC_W  = twcb_pkg::OCC_W;
    localparam int TOTW   = twcb_pkg::TOTAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RETIRE,
        S_MATCH,
        S_APPEND,
        S_FENCE
    } t_state;

    // Control state
    t_state           r_state;
    t_state           n_state;
    logic [CNTW-1:0]  r_count;
    logic [CNTW-1:0]  n_count;
    logic [TOTW-1:0]  r_cc;
    logic [TOTW-1:0]  n_cc;
    logic [WTW-1:0]   r_wt;
    logic [WTW-1:0]   n_wt;
    logic [RGW-1:0]   r_ring;
    logic [RGW-1:0]   n_ring;
    logic             r_full;
    logic             n_full;
    logic [MWW-1:0]   r_mwait;
    logic [MWW-1:0]   n_mwait;
    logic             r_o_valid;
    logic             n_o_valid;

    // Request and timing payload
    logic             r_type;
    logic             n_type;
    logic [LW-1:0]    r_line;
    logic [LW-1:0]    n_line;
    logic [NW-1:0]    r_now;
    logic [NW-1:0]    n_now;
    logic [SW-1:0]    r_t;
    logic [SW-1:0]    n_t;
    logic [TW-1:0]    r_last;
    logic [TW-1:0]    n_last;
    logic [SW-1:0]    r_chain;
    logic [SW-1:0]    n_chain;
    twcb_pkg::t_res   r_o_data;
    twcb_pkg::t_res   n_o_data;

    logic             w_out_free;
    logic             w_acc_req;
    logic             w_acc_cfg;
    logic             w_pop;
    logic             w_app;
    logic             w_emit;
    logic [SW-1:0]    w_exp_sum;
    logic [SW-1:0]    w_done_sum;
    logic             w_head_exp;
    logic             w_chain_sel;
    logic [SW-1:0]    w_app_start;
    logic [SW-1:0]    w_app_ready;
    logic [SW-1:0]    w_hit_ready;
    logic [SW-1:0]    w_wait_diff;
    logic [RW-1:0]    w_ring_ext;
    logic [RW-1:0]    w_ring_n;
    logic [CNTW-1:0]  w_cap;
    logic             w_tree_hit;
    logic [TW-1:0]    w_tree_start;
    logic [NCELL-1:0] w_hit;
    logic [LW-1:0]    w_line  [NCELL];
    logic [TW-1:0]    w_start [NCELL];
    twcb_pkg::t_cell_ctl w_ctl;

    assign w_acc_req  = i_req.valid && i_req.ready;
    assign w_acc_cfg  = i_cfg.valid && i_cfg.ready;
    assign w_out_free = !r_o_valid || o_res.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_o_valid;
    assign o_res.data  = r_o_data;

    // Clamp the ring size to 2..DEPTH; the ring holds one fewer live entries
    assign w_ring_ext = RW'(r_ring);
    assign w_ring_n   = (w_ring_ext < RW'(2)) ? RW'(2) :
                        (w_ring_ext > RW'(DEPTH)) ? RW'(DEPTH) : w_ring_ext;
    assign w_cap      = CNTW'(w_ring_n - RW'(1));

    // Head entry expiry and completion time
    assign w_exp_sum  = {1'b0, w_start[0]} + SW'(r_wt);
    assign w_done_sum = w_exp_sum + SW'(1);
    assign w_head_exp = (r_count != '0) && (r_t > w_exp_sum);

    // New entry starts no earlier than the previous one plus the write time
    assign w_chain_sel = (r_count != '0) && (r_chain > r_t);
    assign w_app_start = w_chain_sel ? r_chain : r_t;
    assign w_app_ready = w_app_start + SW'(r_wt);
    assign w_hit_ready = {1'b0, w_tree_start} + SW'(r_wt);
    assign w_wait_diff = r_t - SW'(r_now);

    assign w_ctl.pop    = w_pop;
    assign w_ctl.append = w_app;
    assign w_ctl.line   = r_line;
    assign w_ctl.start  = w_app_start[TW-1:0];

    // Row of entry cells, cell 0 at the head
    for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
        logic          w_live;
        logic          w_load;
        logic [LW-1:0] w_nl;
        logic [TW-1:0] w_ns;

        assign w_live = CNTW'(gi) < r_count;
        assign w_load = CNTW'(gi) == r_count;

        if (gi + 1 < NCELL) begin : g_mid
            assign w_nl = w_line[gi+1];
            assign w_ns = w_start[gi+1];
        end else begin : g_end
            assign w_nl = '0;
            assign w_ns = '0;
        end

        twcb_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_live       (w_live),
            .i_load       (w_load),
            .i_next_line  (w_nl),
            .i_next_start (w_ns),
            .o_line       (w_line[gi]),
            .o_start      (w_start[gi]),
            .o_hit        (w_hit[gi])
        );
    end

    twcb_hit_tree #(
        .N (NCELL)
    ) u_tree (
        .i_clk   (i_clk),
        .i_hit   (w_hit),
        .i_start (w_start),
        .o_hit   (w_tree_hit),
        .o_start (w_tree_start)
    );

    // Sequence one item: retire expired heads, match, append or drain, then emit; write time 0 passes through
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cc      = r_cc;
        n_wt      = r_wt;
        n_ring    = r_ring;
        n_full    = r_full;
        n_mwait   = r_mwait;
        n_type    = r_type;
        n_line    = r_line;
        n_now     = r_now;
        n_t       = r_t;
        n_last    = r_last;
        n_chain   = {1'b0, r_last} + SW'(r_wt);
        n_o_data  = r_o_data;
        w_pop     = 1'b0;
        w_app     = 1'b0;
        w_emit    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_acc_req) begin
                    n_type  = i_req.data.req_type;
                    n_line  = i_req.data.byte_address[twcb_pkg::ADDR_W-1:twcb_pkg::LINE_SHIFT];
                    n_now   = i_req.data.now_ns;
                    n_t     = SW'(i_req.data.now_ns);
                    n_full  = 1'b0;
                    n_state = S_RETIRE;
                end
            end
            S_RETIRE: begin
                if (r_wt == '0) begin
                    // Buffering off: pass the request straight through
                    if (w_out_free) begin
                        w_emit                 = 1'b1;
                        n_o_data.combined      = 1'b0;
                        n_o_data.wait_ns       = '0;
                        n_o_data.ready_time    = TW'(r_now);
                        n_o_data.occupancy     = OCC_W'(r_count);
                        n_o_data.combine_total = r_cc;
                        n_state                = S_IDLE;
                    end
                end else if (r_type == twcb_pkg::REQ_FENCE) begin
                    n_state = S_FENCE;
                end else if (w_head_exp) begin
                    w_pop = 1'b1;
                end else if (r_full) begin
                    n_state = S_APPEND;
                end else begin
                    n_state = S_MATCH;
                    n_mwait = MWW'(LVLS - 1);
                end
            end
            S_MATCH: begin
                if (r_mwait != '0) begin
                    n_mwait = r_mwait - MWW'(1);
                end else if (w_tree_hit) begin
                    if (w_out_free) begin
                        w_emit                 = 1'b1;
                        n_cc                   = r_cc + TOTW'(1);
                        n_o_data.combined      = 1'b1;
                        n_o_data.wait_ns       = '0;
                        n_o_data.ready_time    = w_hit_ready[TW-1:0];
                        n_o_data.occupancy     = OCC_W'(r_count);
                        n_o_data.combine_total = r_cc + TOTW'(1);
                        n_state                = S_IDLE;
                    end
                end else if (r_count != w_cap) begin
                    if (w_out_free) begin
                        w_app                  = 1'b1;
                        w_emit                 = 1'b1;
                        n_o_data.combined      = 1'b0;
                        n_o_data.wait_ns       = '0;
                        n_o_data.ready_time    = w_app_ready[TW-1:0];
                        n_o_data.occupancy     = OCC_W'(r_count + CNTW'(1));
                        n_o_data.combine_total = r_cc;
                        n_state                = S_IDLE;
                    end
                end else begin
                    // Ring full: move the request time past the head's completion, then retire again
                    n_t     = w_done_sum;
                    n_full  = 1'b1;
                    n_state = S_RETIRE;
                end
            end
            S_APPEND: begin
                if (w_out_free) begin
                    w_app                  = 1'b1;
                    w_emit                 = 1'b1;
                    n_full                 = 1'b0;
                    n_o_data.combined      = 1'b0;
                    n_o_data.wait_ns       = w_wait_diff[TW-1:0];
                    n_o_data.ready_time    = w_app_ready[TW-1:0];
                    n_o_data.occupancy     = OCC_W'(r_count + CNTW'(1));
                    n_o_data.combine_total = r_cc;
                    n_state                = S_IDLE;
                end
            end
            S_FENCE: begin
                if (r_count != '0) begin
                    // Drain one entry a cycle, tracking the latest completion
                    w_pop = 1'b1;
                    if (w_done_sum > r_t) begin
                        n_t = w_done_sum;
                    end
                end else if (w_out_free) begin
                    w_emit                 = 1'b1;
                    n_o_data.combined      = 1'b0;
                    n_o_data.wait_ns       = w_wait_diff[TW-1:0];
                    n_o_data.ready_time    = r_t[TW-1:0];
                    n_o_data.occupancy     = '0;
                    n_o_data.combine_total = r_cc;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_pop) begin
            n_count = r_count - CNTW'(1);
        end
        if (w_app) begin
            n_count = r_count + CNTW'(1);
            n_last  = w_app_start[TW-1:0];
        end

        if (w_emit) begin
            n_o_valid = 1'b1;
        end else if (o_res.ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end

        // Register writes; a ring size write empties the ring
        if (w_acc_cfg) begin
            case (i_cfg.data.index)
                twcb_pkg::CFG_WRITE_TIME: begin
                    n_wt = i_cfg.data.value[WTW-1:0];
                end
                twcb_pkg::CFG_RING_SIZE: begin
                    n_ring  = i_cfg.data.value[RGW-1:0];
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cc      <= '0;
            r_wt      <= '0;
            r_ring    <= twcb_pkg::RING_RESET;
            r_full    <= 1'b0;
            r_mwait   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cc      <= n_cc;
            r_wt      <= n_wt;
            r_ring    <= n_ring;
            r_full    <= n_full;
            r_mwait   <= n_mwait;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_line   <= n_line;
        r_now    <= n_now;
        r_t      <= n_t;
        r_last   <= n_last;
        r_chain  <= n_chain;
        r_o_data <= n_o_data;
    end

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= w_cap)
        else $error("live entry count above ring capacity");

    a_unique_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one live entry holds the requested line");

    a_pop_app: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_app))
        else $error("pop and append in the same cycle");

    a_pop_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_count == $past(r_count) - CNTW'(1)) || $past(w_acc_cfg))
        else $error("pop did not remove exactly one entry");
`endif

endmodule
